/* src/sbp_pkg.sv */
package sbp_pkg;

    typedef enum logic [6:0] {
        PH_TYPE    = 7'b0000001,
        PH_STRLEN  = 7'b0000010,
        PH_STRCHAR = 7'b0000100,
        PH_TERM    = 7'b0001000,
        PH_COUNT   = 7'b0010000,
        PH_MASK    = 7'b0100000,
        PH_TRAIL   = 7'b1000000
    } t_phase;

    localparam logic [2:0] FK_TYPE     = 3'd0;
    localparam logic [2:0] FK_STRLEN   = 3'd1;
    localparam logic [2:0] FK_STRCHAR  = 3'd2;
    localparam logic [2:0] FK_TERM     = 3'd3;
    localparam logic [2:0] FK_COUNT    = 3'd4;
    localparam logic [2:0] FK_MASK     = 3'd5;
    localparam logic [2:0] FK_TRAIL    = 3'd6;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_VERSION = 3'd1;
    localparam logic [2:0] ST_TRUNCATED   = 3'd2;
    localparam logic [2:0] ST_BAD_TERM    = 3'd3;
    localparam logic [2:0] ST_FLAG_CLEAR  = 3'd4;

    localparam logic       KIND_REQUEST  = 1'b0;
    localparam logic [3:0] MIN_LEN_REQ   = 4'd10;
    localparam logic [3:0] MIN_LEN_RESP  = 4'd2;
    localparam logic [3:0] SEEN_LIMIT    = 4'd10;
    localparam logic [7:0] COUNT_NO_MASK = 8'hff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] header_version;
    } t_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic [2:0] field_kind;
        logic [1:0] string_index;
        logic       message_done;
        logic [2:0] status;
        logic       sender;
        logic       mask_present;
        logic [7:0] track_count;
    } t_result;

endpackage

/* src/sbp_in_if.sv */
interface sbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] header_version;

    modport source (output valid, input ready, output data_byte, output first_byte,
                    output last_byte, output header_version);
    modport sink (input valid, output ready, input data_byte, input first_byte,
                  input last_byte, input header_version);
endinterface

/* src/sbp_out_if.sv */
interface sbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic [2:0] field_kind;
    logic [1:0] string_index;
    logic       message_done;
    logic [2:0] status;
    logic       sender;
    logic       mask_present;
    logic [7:0] track_count;

    modport source (output valid, input ready, output data_out, output field_kind,
                    output string_index, output message_done, output status,
                    output sender, output mask_present, output track_count);
    modport sink (input valid, output ready, input data_out, input field_kind,
                  input string_index, input message_done, input status,
                  input sender, input mask_present, input track_count);
endinterface

/* src/sbp_parse.sv */
module sbp_parse #(
    parameter int MASK_BYTES   = 32,
    parameter int STRING_COUNT = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_accept,
    input  sbp_pkg::t_item   i_item,
    output sbp_pkg::t_result o_result
);

    localparam int MPW = $clog2(MASK_BYTES + 1);
    localparam int SW  = (STRING_COUNT > 1) ? $clog2(STRING_COUNT) : 1;

    logic              r_message_kind;
    sbp_pkg::t_phase   r_phase, n_phase;
    logic [SW-1:0]     r_string_number, n_string_number;
    logic [7:0]        r_skip_left, n_skip_left;
    logic [MPW-1:0]    r_mask_position, n_mask_position;
    logic [3:0]        r_bytes_seen, n_bytes_seen;
    logic [2:0]        r_error_code, n_error_code;
    logic              r_sender_flag, n_sender_flag;
    logic [7:0]        r_bit_total, n_bit_total;
    logic              r_mask_flag, n_mask_flag;

    always_comb begin
        logic [7:0] d;
        logic [7:0] counted;
        logic [3:0] ones;
        logic [3:0] min_len;
        logic [2:0] kind;
        logic [1:0] sidx;
        logic [2:0] status;

        d = i_item.data_byte;
        kind = sbp_pkg::FK_TRAIL;
        sidx = 2'd0;
        status = sbp_pkg::ST_OK;
        ones = 4'd0;

        if (i_item.first_byte || r_phase == sbp_pkg::PH_TYPE) begin
            n_phase = sbp_pkg::PH_TYPE;
            n_string_number = '0;
            n_skip_left = 8'd0;
            n_mask_position = '0;
            n_bytes_seen = 4'd0;
            n_error_code = (i_item.header_version == 8'd0) ? sbp_pkg::ST_BAD_VERSION
                                                          : sbp_pkg::ST_OK;
            n_sender_flag = 1'b0;
            n_bit_total = 8'd0;
            n_mask_flag = 1'b0;
        end else begin
            n_phase = r_phase;
            n_string_number = r_string_number;
            n_skip_left = r_skip_left;
            n_mask_position = r_mask_position;
            n_bytes_seen = r_bytes_seen;
            n_error_code = r_error_code;
            n_sender_flag = r_sender_flag;
            n_bit_total = r_bit_total;
            n_mask_flag = r_mask_flag;
        end

        if (n_bytes_seen < sbp_pkg::SEEN_LIMIT) begin
            n_bytes_seen = n_bytes_seen + 4'd1;
        end

        // Bit 0 of the first mask byte is not counted.
        counted = {d[7:1], d[0] & (n_mask_position != '0)};
        for (int i = 0; i < 8; i++) begin
            ones = ones + 4'(counted[i]);
        end

        unique case (n_phase)
            sbp_pkg::PH_TYPE: begin
                kind = sbp_pkg::FK_TYPE;
                if (r_message_kind != sbp_pkg::KIND_REQUEST) begin
                    if (!d[0]) begin
                        if (n_error_code == sbp_pkg::ST_OK) begin
                            n_error_code = sbp_pkg::ST_FLAG_CLEAR;
                        end
                        n_phase = sbp_pkg::PH_TRAIL;
                    end else begin
                        n_phase = sbp_pkg::PH_COUNT;
                    end
                end else begin
                    n_sender_flag = d[0];
                    n_phase = sbp_pkg::PH_STRLEN;
                end
            end
            sbp_pkg::PH_STRLEN: begin
                kind = sbp_pkg::FK_STRLEN;
                sidx = 2'(n_string_number);
                n_skip_left = d;
                n_phase = (d == 8'd0) ? sbp_pkg::PH_TERM : sbp_pkg::PH_STRCHAR;
            end
            sbp_pkg::PH_STRCHAR: begin
                kind = sbp_pkg::FK_STRCHAR;
                sidx = 2'(n_string_number);
                n_skip_left = n_skip_left - 8'd1;
                if (n_skip_left == 8'd0) begin
                    n_phase = sbp_pkg::PH_TERM;
                end
            end
            sbp_pkg::PH_TERM: begin
                kind = sbp_pkg::FK_TERM;
                sidx = 2'(n_string_number);
                if (d != 8'd0) begin
                    if (n_error_code == sbp_pkg::ST_OK) begin
                        n_error_code = sbp_pkg::ST_BAD_TERM;
                    end
                    n_phase = sbp_pkg::PH_TRAIL;
                end else if (n_string_number == SW'(STRING_COUNT - 1)) begin
                    n_string_number = '0;
                    n_phase = sbp_pkg::PH_COUNT;
                end else begin
                    n_string_number = n_string_number + SW'(1);
                    n_phase = sbp_pkg::PH_STRLEN;
                end
            end
            sbp_pkg::PH_COUNT: begin
                kind = sbp_pkg::FK_COUNT;
                if (d == sbp_pkg::COUNT_NO_MASK) begin
                    n_phase = sbp_pkg::PH_TRAIL;
                end else begin
                    n_mask_flag = 1'b1;
                    n_mask_position = '0;
                    n_phase = sbp_pkg::PH_MASK;
                end
            end
            sbp_pkg::PH_MASK: begin
                kind = sbp_pkg::FK_MASK;
                n_bit_total = n_bit_total + 8'(ones);
                n_mask_position = n_mask_position + MPW'(1);
                if (n_mask_position == MPW'(MASK_BYTES)) begin
                    n_phase = sbp_pkg::PH_TRAIL;
                end
            end
            sbp_pkg::PH_TRAIL: begin
                kind = sbp_pkg::FK_TRAIL;
            end
            default: begin
                kind = sbp_pkg::FK_TRAIL;
                n_phase = sbp_pkg::PH_TRAIL;
            end
        endcase

        min_len = (r_message_kind != sbp_pkg::KIND_REQUEST) ? sbp_pkg::MIN_LEN_RESP
                                                           : sbp_pkg::MIN_LEN_REQ;
        if (i_item.last_byte) begin
            if (n_bytes_seen < min_len) begin
                status = sbp_pkg::ST_BAD_VERSION;
            end else if (n_error_code != sbp_pkg::ST_OK) begin
                status = n_error_code;
            end else if (n_phase != sbp_pkg::PH_TRAIL) begin
                status = sbp_pkg::ST_TRUNCATED;
            end else begin
                status = sbp_pkg::ST_OK;
            end
        end

        o_result.data_out = d;
        o_result.field_kind = kind;
        o_result.string_index = sidx;
        o_result.message_done = i_item.last_byte;
        o_result.status = status;
        o_result.sender = (r_message_kind != sbp_pkg::KIND_REQUEST) ? 1'b0 : n_sender_flag;
        o_result.mask_present = n_mask_flag;
        o_result.track_count = n_bit_total;

        // The next byte after the last one sees the type phase and clears the rest.
        if (i_item.last_byte) begin
            n_phase = sbp_pkg::PH_TYPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_kind <= sbp_pkg::KIND_REQUEST;
        end else if (i_cfg_we) begin
            r_message_kind <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sbp_pkg::PH_TYPE;
            r_string_number <= '0;
            r_skip_left <= 8'd0;
            r_mask_position <= '0;
            r_bytes_seen <= 4'd0;
            r_error_code <= sbp_pkg::ST_OK;
            r_sender_flag <= 1'b0;
            r_bit_total <= 8'd0;
            r_mask_flag <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_string_number <= n_string_number;
            r_skip_left <= n_skip_left;
            r_mask_position <= n_mask_position;
            r_bytes_seen <= n_bytes_seen;
            r_error_code <= n_error_code;
            r_sender_flag <= n_sender_flag;
            r_bit_total <= n_bit_total;
            r_mask_flag <= n_mask_flag;
        end
    end

endmodule

/* src/sbp_skid.sv */
module sbp_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sbp_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output sbp_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    sbp_pkg::t_result r_out;
    sbp_pkg::t_result r_skid;
    logic             w_accept;
    logic             w_load;

    assign o_ready  = !r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign w_load   = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= r_skid_valid || w_accept;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (w_accept) begin
            r_skid <= i_data;
        end
    end

endmodule

/* src/stream_handshake_body_parser.sv */
// Accepted results go to the output register, or to the skid entry on a stall.
// Throughput: one byte per cycle unless a sink stall fills the output buffer.
// A two-entry output buffer keeps input ready registered while the sink stalls.
// Reset is synchronous and active low: parsing waits for a type byte, the kind
// register selects request bodies, and the output buffer is empty.
module stream_handshake_body_parser #(
    parameter int MASK_BYTES   = 32,
    parameter int STRING_COUNT = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_data,
    sbp_in_if.sink    i_in,
    sbp_out_if.source o_out
);

    logic             w_ready;
    logic             w_accept;
    sbp_pkg::t_item   w_item;
    sbp_pkg::t_result w_result;
    sbp_pkg::t_result w_out;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    assign w_item.data_byte      = i_in.data_byte;
    assign w_item.first_byte     = i_in.first_byte;
    assign w_item.last_byte      = i_in.last_byte;
    assign w_item.header_version = i_in.header_version;

    sbp_parse #(
        .MASK_BYTES   (MASK_BYTES),
        .STRING_COUNT (STRING_COUNT)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (w_item),
        .o_result   (w_result)
    );

    sbp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_ready),
        .i_data  (w_result),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_out)
    );

    assign o_out.data_out     = w_out.data_out;
    assign o_out.field_kind   = w_out.field_kind;
    assign o_out.string_index = w_out.string_index;
    assign o_out.message_done = w_out.message_done;
    assign o_out.status       = w_out.status;
    assign o_out.sender       = w_out.sender;
    assign o_out.mask_present = w_out.mask_present;
    assign o_out.track_count  = w_out.track_count;

`ifndef SYNTHESIS
    // After every accepted transaction the output holds a valid result in the next cycle.
    a_accept_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out.valid)
        else $error("accepted transaction did not reach the output register");

    // The input side only stalls when both buffer entries are occupied.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ready |-> (o_out.valid && !$past(o_out.ready)))
        else $error("input stalled while the output register was free");

    // A status other than ok is only reported on the last byte of a message.
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != sbp_pkg::ST_OK) |-> o_out.message_done)
        else $error("status reported on a byte that does not end the message");

    // Only string bytes carry a string index.
    a_index_on_strings: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.field_kind != sbp_pkg::FK_STRLEN
         && o_out.field_kind != sbp_pkg::FK_STRCHAR
         && o_out.field_kind != sbp_pkg::FK_TERM) |-> (o_out.string_index == 2'd0))
        else $error("string index set on a byte outside the strings");
`endif

endmodule
